// File: rtl/core/dfp_pkg.sv
// ----------------------------------------------------------------------------
// dfp_pkg
// Shared constants and types for the distance frame parser.
// ----------------------------------------------------------------------------
package dfp_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned DIST_W = 16;
	localparam int unsigned TICK_W = 16;
	localparam int unsigned CFG_W  = 16;

	localparam int unsigned CFG_COUNT = 2;
	localparam int unsigned CFG_IDX_W = $clog2(CFG_COUNT);

	localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_LOWER_LIMIT  = CFG_IDX_W'(1);

	localparam logic [CFG_W-1:0] MIN_INTERVAL_RST = CFG_W'(100);
	localparam logic [CFG_W-1:0] LOWER_LIMIT_RST  = CFG_W'(30);

	localparam logic [BYTE_W-1:0] HDR_BYTE = 8'hFF;
	localparam logic [TICK_W-1:0] TICK_MAX = '1;

	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_CKERR = 1'b1;

	localparam logic [1:0] POS_HUNT = 2'd0;
	localparam logic [1:0] POS_HIGH = 2'd1;
	localparam logic [1:0] POS_LOW  = 2'd2;
	localparam logic [1:0] POS_CHK  = 2'd3;

	typedef struct packed {
		logic              fire;
		logic              status;
		logic [DIST_W-1:0] distance_mm;
		logic [DIST_W-1:0] held_distance_mm;
	} result_t;

endpackage

// File: rtl/core/dfp_if.sv
// ----------------------------------------------------------------------------
// dfp_in_if / dfp_out_if
// Valid-ready channels for input beats and result beats.
// ----------------------------------------------------------------------------
interface dfp_in_if;
	logic                       valid;
	logic                       ready;
	logic                       cmd;
	logic [dfp_pkg::BYTE_W-1:0] rx_byte;

	modport source (output valid, output cmd, output rx_byte, input ready);
	modport sink (input valid, input cmd, input rx_byte, output ready);
endinterface

interface dfp_out_if;
	logic                       valid;
	logic                       ready;
	logic                       status;
	logic [dfp_pkg::DIST_W-1:0] distance_mm;
	logic [dfp_pkg::DIST_W-1:0] held_distance_mm;

	modport source (output valid, output status, output distance_mm,
		output held_distance_mm, input ready);
	modport sink (input valid, input status, input distance_mm,
		input held_distance_mm, output ready);
endinterface

// File: rtl/core/dfp_parser.sv
// ----------------------------------------------------------------------------
// dfp_parser
// Frame state, tick counter and held distance; builds the result of one beat.
// ----------------------------------------------------------------------------
module dfp_parser (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  logic                        cmd,
	input  logic [dfp_pkg::BYTE_W-1:0]  rx_byte,
	input  logic [dfp_pkg::CFG_W-1:0]   min_interval_ticks,
	input  logic [dfp_pkg::CFG_W-1:0]   floor_mm,
	output dfp_pkg::result_t            result
);

	logic [1:0]                       pos_q;
	logic [dfp_pkg::BYTE_W-1:0]       high_q;
	logic [dfp_pkg::BYTE_W-1:0]       low_q;
	logic [dfp_pkg::TICK_W-1:0]       ticks_q;
	logic [dfp_pkg::DIST_W-1:0]       last_q;

	logic [1:0]                       pos_d;
	logic [dfp_pkg::BYTE_W-1:0]       high_d;
	logic [dfp_pkg::BYTE_W-1:0]       low_d;
	logic [dfp_pkg::TICK_W-1:0]       ticks_d;
	logic [dfp_pkg::DIST_W-1:0]       last_d;
	logic [dfp_pkg::BYTE_W-1:0]       sum;
	logic [dfp_pkg::DIST_W-1:0]       raw_dist;
	logic [dfp_pkg::DIST_W-1:0]       clamped;
	dfp_pkg::result_t                 res;

	assign sum      = dfp_pkg::HDR_BYTE + high_q + low_q;
	assign raw_dist = {high_q, low_q};
	assign clamped  = (raw_dist < floor_mm) ? floor_mm : raw_dist;

	always_comb begin
		pos_d   = pos_q;
		high_d  = high_q;
		low_d   = low_q;
		ticks_d = ticks_q;
		last_d  = last_q;
		res.fire             = 1'b0;
		res.status           = dfp_pkg::STATUS_OK;
		res.distance_mm      = '0;
		res.held_distance_mm = last_q;
		if (cmd == dfp_pkg::CMD_TICK) begin
			if (ticks_q != dfp_pkg::TICK_MAX) begin
				ticks_d = ticks_q + 1'b1;
			end
		end else begin
			case (pos_q)
				dfp_pkg::POS_HUNT: begin
					if (rx_byte == dfp_pkg::HDR_BYTE) begin
						pos_d = dfp_pkg::POS_HIGH;
					end
				end
				dfp_pkg::POS_HIGH: begin
					high_d = rx_byte;
					pos_d  = dfp_pkg::POS_LOW;
				end
				dfp_pkg::POS_LOW: begin
					low_d = rx_byte;
					pos_d = dfp_pkg::POS_CHK;
				end
				default: begin
					pos_d = dfp_pkg::POS_HUNT;
					if (ticks_q >= min_interval_ticks) begin
						ticks_d  = '0;
						res.fire = 1'b1;
						if (sum != rx_byte) begin
							res.status = dfp_pkg::STATUS_CKERR;
						end else begin
							res.distance_mm      = clamped;
							res.held_distance_mm = clamped;
							last_d               = clamped;
						end
					end
				end
			endcase
		end
	end

	assign result = res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= dfp_pkg::POS_HUNT;
			high_q  <= '0;
			low_q   <= '0;
			ticks_q <= dfp_pkg::TICK_MAX;
			last_q  <= '0;
		end else if (accept) begin
			pos_q   <= pos_d;
			high_q  <= high_d;
			low_q   <= low_d;
			ticks_q <= ticks_d;
			last_q  <= last_d;
		end
	end

endmodule

// File: rtl/core/distance_frame_parser.sv
// ----------------------------------------------------------------------------
// distance_frame_parser
// Parses header/distance/checksum frames from a byte and tick stream.
// ----------------------------------------------------------------------------
//   Channel    Direction  Carries
//   in_chan    sink       cmd, rx_byte (byte or millisecond tick)
//   out_chan   source     status, distance_mm, held_distance_mm
//   cfg_*      write      min_interval_ticks (0), distance floor (1)
//
// One beat per cycle while ready; a result shows the cycle after its checksum.
// The result register frees in the same cycle it is taken, so input is
// stalled only while a result waits and out_chan.ready is low.
// Reset clears the frame position and held distance, saturates the tick
// counter and loads the configuration defaults.
// ----------------------------------------------------------------------------
module distance_frame_parser (
	input  logic                            clk,
	input  logic                            arst_n,
	dfp_in_if.sink                          in_chan,
	dfp_out_if.source                       out_chan,
	input  logic                            cfg_we,
	input  logic [dfp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [dfp_pkg::CFG_W-1:0]       cfg_wdata
);

	logic [dfp_pkg::CFG_W-1:0]  min_interval_q;
	logic [dfp_pkg::CFG_W-1:0]  lower_limit_q;
	logic                       out_valid_q;
	logic                       status_q;
	logic [dfp_pkg::DIST_W-1:0] dist_q;
	logic [dfp_pkg::DIST_W-1:0] held_q;
	logic                       accept;
	dfp_pkg::result_t           result;

	assign in_chan.ready = !out_valid_q || out_chan.ready;
	assign accept        = in_chan.valid && in_chan.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_interval_q <= dfp_pkg::MIN_INTERVAL_RST;
			lower_limit_q  <= dfp_pkg::LOWER_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				dfp_pkg::CFG_MIN_INTERVAL: min_interval_q <= cfg_wdata;
				dfp_pkg::CFG_LOWER_LIMIT:  lower_limit_q  <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	dfp_parser u_parser (
		.clk                (clk),
		.arst_n             (arst_n),
		.accept             (accept),
		.cmd                (in_chan.cmd),
		.rx_byte            (in_chan.rx_byte),
		.min_interval_ticks (min_interval_q),
		.floor_mm           (lower_limit_q),
		.result             (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && result.fire) begin
			out_valid_q <= 1'b1;
		end else if (out_chan.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && result.fire) begin
			status_q <= result.status;
			dist_q   <= result.distance_mm;
			held_q   <= result.held_distance_mm;
		end
	end

	assign out_chan.valid            = out_valid_q;
	assign out_chan.status           = status_q;
	assign out_chan.distance_mm      = dist_q;
	assign out_chan.held_distance_mm = held_q;

endmodule
